// ===== rtl/jl2bh_pkg.sv =====
// Shared types, constants and the mixing step of the lookup2 byte hash unit.
package jl2bh_pkg;

  localparam logic [31:0] Golden     = 32'h9e3779b9;
  localparam logic [15:0] ShortMask  = 16'hFFFF;
  localparam logic [3:0]  BlockLast  = 4'd11;
  localparam int unsigned MixSteps   = 9;
  localparam logic [3:0]  MixLast    = 4'(MixSteps - 1);
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned ResultW    = 48;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lanes_t;

  // One queued piece of work for the mixing engine.
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] len;
    logic [31:0] seed;
    logic        first;
    logic        mix_block;
    logic        is_final;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StMix,
    StLen,
    StFinalMix,
    StOut
  } back_state_e;

  // One line of the lookup2 mix: a single lane is updated per step.
  function automatic lanes_t mix_line(input logic [3:0] step, input lanes_t l);
    lanes_t r;
    r = l;
    unique case (step)
      4'd0: r.a = (l.a - l.b - l.c) ^ (l.c >> 13);
      4'd1: r.b = (l.b - l.c - l.a) ^ (l.a << 8);
      4'd2: r.c = (l.c - l.a - l.b) ^ (l.b >> 13);
      4'd3: r.a = (l.a - l.b - l.c) ^ (l.c >> 12);
      4'd4: r.b = (l.b - l.c - l.a) ^ (l.a << 16);
      4'd5: r.c = (l.c - l.a - l.b) ^ (l.b >> 5);
      4'd6: r.a = (l.a - l.b - l.c) ^ (l.c >> 3);
      4'd7: r.b = (l.b - l.c - l.a) ^ (l.a << 10);
      4'd8: r.c = (l.c - l.a - l.b) ^ (l.b >> 15);
      default: r = l;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/jenkins_lookup2_byte_hash_unit.sv =====
// Top level of the lookup2 byte hash unit: seed register, front end, queue and mixer.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: data_byte; tlast: last_byte; tuser: empty_message
//   m_axis    out        tdata: hash_full, hash_short
//   cfg       in         cfg_data_i: seed_value
//
// One byte is taken per cycle while the queue has room. A 12-byte block costs the mixer
// an add and nine mix lines; closing a message costs an add, the length, nine mix lines
// and the output, plus the block's nine mix lines first when its last byte completes a
// block, so long messages stream at full rate and short ones are paced by the mixer.
// Reset zeroes the seed; the golden constant enters the lanes as each message starts.
// Either side may stall; the four-entry queue and the output register absorb it.
module jenkins_lookup2_byte_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // [0] empty_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] hash_full, [47:32] hash_short
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic              push, full, pop, empty;
  logic [31:0]       seed_q;
  jl2bh_pkg::entry_t push_entry, pop_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i) begin
      seed_q <= cfg_data_i;
    end
  end

  jl2bh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_empty_i (s_axis_tuser),
    .seed_i     (seed_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  jl2bh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  jl2bh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/jl2bh_front.sv =====
// Front end: accepts message bytes, packs them into block words and queues work.
module jl2bh_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  input  logic               in_empty_i,
  input  logic [31:0]        seed_i,
  input  logic               full_i,
  output logic               push_o,
  output jl2bh_pkg::entry_t  entry_o
);

  logic [31:0] w0_q, w0_d, w1_q, w1_d, len_q, len_d, seed_q, seed_d;
  logic [23:0] tb_q, tb_d;
  logic [3:0]  pos_q, pos_d;
  logic        in_msg_q, in_msg_d, sent_q, sent_d;
  logic        accept, has_byte, block_done;
  logic [4:0]  shamt;
  logic [31:0] byte32, msg_seed;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign has_byte   = !in_empty_i;
  assign block_done = has_byte && (pos_q == jl2bh_pkg::BlockLast);
  assign byte32     = {24'd0, in_byte_i};
  assign shamt      = {pos_q[1:0], 3'b000};
  assign msg_seed   = in_msg_q ? seed_q : seed_i;

  always_comb begin
    w0_d     = w0_q;
    w1_d     = w1_q;
    tb_d     = tb_q;
    pos_d    = pos_q;
    len_d    = len_q;
    in_msg_d = in_msg_q;
    sent_d   = sent_q;
    seed_d   = seed_q;
    if (has_byte) begin
      len_d = len_q + 32'd1;
      if (!in_msg_q) begin
        seed_d = seed_i;
      end
      in_msg_d = 1'b1;
      if (pos_q < 4'd4) begin
        w0_d = w0_q | (byte32 << shamt);
      end else if (pos_q < 4'd8) begin
        w1_d = w1_q | (byte32 << shamt);
      end else if (!block_done) begin
        tb_d = tb_q | (24'(byte32) << shamt);
      end
      pos_d = block_done ? 4'd0 : pos_q + 4'd1;
    end

    entry_o.first = !sent_q;
    entry_o.seed  = msg_seed;
    entry_o.len   = len_d;
    if (block_done) begin
      entry_o.w0        = w0_q;
      entry_o.w1        = w1_q;
      entry_o.w2        = {in_byte_i, tb_q};
      entry_o.mix_block = 1'b1;
      entry_o.is_final  = in_last_i;
    end else begin
      // Tail bytes eight to ten sit one byte up in the third lane.
      entry_o.w0        = w0_d;
      entry_o.w1        = w1_d;
      entry_o.w2        = {tb_d, 8'd0};
      entry_o.mix_block = 1'b0;
      entry_o.is_final  = 1'b1;
    end
    push_o = accept && (block_done || in_last_i);

    if (block_done) begin
      w0_d = '0;
      w1_d = '0;
      tb_d = '0;
    end
    if (push_o) begin
      sent_d = 1'b1;
    end
    if (in_last_i) begin
      w0_d     = '0;
      w1_d     = '0;
      tb_d     = '0;
      pos_d    = '0;
      len_d    = '0;
      in_msg_d = 1'b0;
      sent_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q     <= '0;
      w1_q     <= '0;
      tb_q     <= '0;
      pos_q    <= '0;
      len_q    <= '0;
      in_msg_q <= 1'b0;
      sent_q   <= 1'b0;
      seed_q   <= '0;
    end else if (accept) begin
      w0_q     <= w0_d;
      w1_q     <= w1_d;
      tb_q     <= tb_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      in_msg_q <= in_msg_d;
      sent_q   <= sent_d;
      seed_q   <= seed_d;
    end
  end

endmodule

// ===== rtl/jl2bh_queue.sv =====
// Short work queue between the byte front end and the mixing engine.
module jl2bh_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jl2bh_pkg::entry_t  entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output jl2bh_pkg::entry_t  entry_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = $clog2(jl2bh_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(jl2bh_pkg::QueueDepth + 1);

  jl2bh_pkg::entry_t mem_q [jl2bh_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(jl2bh_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/jl2bh_back.sv =====
// Mixing engine: adds block words into the lanes, runs the mix and holds the result.
module jl2bh_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            empty_i,
  input  jl2bh_pkg::entry_t               entry_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [jl2bh_pkg::ResultW-1:0]   out_data_o
);

  jl2bh_pkg::back_state_e        state_q, state_d;
  logic [3:0]                    step_q, step_d;
  jl2bh_pkg::lanes_t             lanes_q, lanes_d, base, mixed;
  logic [31:0]                   len_q, len_d;
  logic                          final_q, final_d;
  logic                          out_valid_q, out_valid_d;
  logic [jl2bh_pkg::ResultW-1:0] out_data_q, out_data_d;
  logic                          out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign mixed    = jl2bh_pkg::mix_line(step_q, lanes_q);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    lanes_d     = lanes_q;
    len_d       = len_q;
    final_d     = final_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    base        = lanes_q;
    if (entry_i.first) begin
      base = '{a: jl2bh_pkg::Golden, b: jl2bh_pkg::Golden, c: entry_i.seed};
    end

    unique case (state_q)
      jl2bh_pkg::StIdle: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          lanes_d.a = base.a + entry_i.w0;
          lanes_d.b = base.b + entry_i.w1;
          lanes_d.c = base.c + entry_i.w2;
          len_d     = entry_i.len;
          final_d   = entry_i.is_final;
          step_d    = '0;
          state_d   = entry_i.mix_block ? jl2bh_pkg::StMix : jl2bh_pkg::StLen;
        end
      end
      jl2bh_pkg::StMix: begin
        lanes_d = mixed;
        step_d  = step_q + 4'd1;
        if (step_q == jl2bh_pkg::MixLast) begin
          state_d = final_q ? jl2bh_pkg::StLen : jl2bh_pkg::StIdle;
        end
      end
      jl2bh_pkg::StLen: begin
        lanes_d.c = lanes_q.c + len_q;
        step_d    = '0;
        state_d   = jl2bh_pkg::StFinalMix;
      end
      jl2bh_pkg::StFinalMix: begin
        lanes_d = mixed;
        step_d  = step_q + 4'd1;
        if (step_q == jl2bh_pkg::MixLast) begin
          state_d = jl2bh_pkg::StOut;
        end
      end
      jl2bh_pkg::StOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {lanes_q.c[15:0] & jl2bh_pkg::ShortMask, lanes_q.c};
          state_d     = jl2bh_pkg::StIdle;
        end
      end
      default: state_d = jl2bh_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jl2bh_pkg::StIdle;
      step_q      <= '0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q    <= lanes_d;
    len_q      <= len_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== verif/jenkins_lookup2_byte_hash_checker.sv =====
// Checker for the lookup2 byte hash unit: predicts each hash and compares the output transfers.
module jenkins_lookup2_byte_hash_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [7:0] data_byte
  input  logic        s_tlast_i,
  input  logic        s_tuser_i,   // [0] empty_message
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,   // [31:0] hash_full, [47:32] hash_short
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          hashes_pending_o
);

  localparam bit [31:0] GoldenRatio = 32'h9e3779b9;
  localparam int        ReportLimit = 10;

  typedef struct packed {
    bit [31:0] a;
    bit [31:0] b;
    bit [31:0] c;
  } hash_lanes_t;

  typedef struct packed {
    logic [31:0] hash_full;
    logic [15:0] hash_short;
  } hash_result_t;

  bit [31:0]    seed_q = '0;
  hash_lanes_t  lanes;
  bit [31:0]    tail_bytes;
  bit [3:0]     block_pos;
  bit [31:0]    msg_len;
  bit           msg_open;
  hash_result_t expected_hashes[$];
  int           mismatches = 0;

  function automatic hash_lanes_t lookup2_mix(input hash_lanes_t l);
    bit [31:0] a;
    bit [31:0] b;
    bit [31:0] c;
    a = l.a;
    b = l.b;
    c = l.c;
    a = (a - b - c) ^ (c >> 13);
    b = (b - c - a) ^ (a << 8);
    c = (c - a - b) ^ (b >> 13);
    a = (a - b - c) ^ (c >> 12);
    b = (b - c - a) ^ (a << 16);
    c = (c - a - b) ^ (b >> 5);
    a = (a - b - c) ^ (c >> 3);
    b = (b - c - a) ^ (a << 10);
    c = (c - a - b) ^ (b >> 15);
    return '{a: a, b: b, c: c};
  endfunction

  function automatic void restart_lanes();
    lanes     = '{a: GoldenRatio, b: GoldenRatio, c: seed_q};
    tail_bytes = '0;
    block_pos = '0;
    msg_len   = '0;
    msg_open  = 1'b0;
  endfunction

  function automatic void absorb_byte(input bit [7:0] v);
    bit [31:0] wide;
    wide = {24'b0, v};
    if (block_pos < 4) begin
      lanes.a += wide << (8 * block_pos);
    end else if (block_pos < 8) begin
      lanes.b += wide << (8 * (block_pos - 4));
    end else if (block_pos < 11) begin
      // Bytes 8 to 10 wait here until the block is complete or the message ends.
      tail_bytes |= wide << (8 * (block_pos - 8));
    end else begin
      lanes.c += tail_bytes + (wide << 24);
      lanes = lookup2_mix(lanes);
      tail_bytes = '0;
    end
    block_pos = (block_pos == 4'd11) ? 4'd0 : block_pos + 4'd1;
    msg_len += 1;
    msg_open = 1'b1;
  endfunction

  function automatic void close_message();
    hash_result_t r;
    // An open tail sits one byte higher in the third lane than within a full block.
    lanes.c += tail_bytes << 8;
    lanes.c += msg_len;
    lanes = lookup2_mix(lanes);
    r.hash_full  = lanes.c;
    r.hash_short = lanes.c[15:0];
    expected_hashes.push_back(r);
    restart_lanes();
  endfunction

  always @(posedge clk_i) begin : hash_check
    hash_result_t seen;
    hash_result_t want;
    if (!rst_ni) begin
      seed_q = '0;
      restart_lanes();
      expected_hashes.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        seen.hash_full  = m_tdata_i[31:0];
        seen.hash_short = m_tdata_i[47:32];
        if (expected_hashes.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("unexpected hash transfer: full %08h short %04h",
                     seen.hash_full, seen.hash_short);
        end else begin
          want = expected_hashes.pop_front();
          if (seen.hash_full !== want.hash_full || seen.hash_short !== want.hash_short) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("hash mismatch: expected full %08h short %04h, got full %08h short %04h",
                       want.hash_full, want.hash_short, seen.hash_full, seen.hash_short);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (!s_tuser_i) absorb_byte(s_tdata_i);
        if (s_tlast_i) close_message();
      end
      if (cfg_valid_i && cfg_ready_i) begin
        seed_q = cfg_data_i;
        if (!msg_open) lanes.c = seed_q;
      end
    end
    mismatch_count_o <= mismatches;
    hashes_pending_o <= expected_hashes.size();
  end

endmodule

// ===== verif/jenkins_lookup2_byte_hash_unit_tb.sv =====
// Testbench top for the lookup2 byte hash unit: clock, reset, stimulus and verdict.
module jenkins_lookup2_byte_hash_unit_tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned PhaseItems  = 160;
  localparam int unsigned PhaseCount  = 6;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i    = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_tog      = 1'b0;
  logic        hold_seen     = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned phase_items   = 0;
  int          mismatch_total;
  int          hashes_pending;

  always #4 clk_i = ~clk_i;

  jenkins_lookup2_byte_hash_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  jenkins_lookup2_byte_hash_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tlast_i        (s_axis_tlast),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_total),
    .hashes_pending_o (hashes_pending)
  );

  // Output side: random back-pressure, or a long hold-off each time hold_tog flips.
  always @(posedge clk_i) begin
    if (hold_tog != hold_seen) begin
      hold_seen     <= hold_tog;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("jenkins_lookup2_byte_hash_unit test failed");
      $finish;
    end
  end

  // Offers one item and returns once its transfer has happened.
  task automatic offer_byte(input logic [7:0] b, input logic last, input logic empty);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    s_axis_tuser  <= empty;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!empty || last) phase_items++;
  endtask

  // A message of n_bytes random bytes with occasional ignored empty items in between.
  // With close_empty set, or with no bytes at all, an empty item carries the last flag.
  task automatic send_message(input int unsigned n_bytes, input bit close_empty);
    int unsigned i;
    for (i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < 4) offer_byte(8'($urandom), 1'b0, 1'b1);
      offer_byte(8'($urandom), (i == n_bytes - 1) && !close_empty, 1'b0);
    end
    if (n_bytes == 0 || close_empty) offer_byte(8'($urandom), 1'b1, 1'b1);
  endtask

  // The seed is only written once every hash has left and the mixer has settled.
  task automatic write_seed(input logic [31:0] seed);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (hashes_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= seed;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] seed_plan [PhaseCount];
    int unsigned phase;
    int unsigned k;
    int unsigned pick;
    int unsigned n_bytes;

    seed_plan[0] = 32'hFFFF_FFFF;
    seed_plan[1] = $urandom;
    seed_plan[2] = 32'h0000_0000;
    seed_plan[3] = $urandom;
    seed_plan[4] = 32'h0000_0001;
    seed_plan[5] = $urandom;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, seed left at its reset value.
    offer_byte(8'h00, 1'b1, 1'b1);
    offer_byte(8'hA5, 1'b0, 1'b1);
    offer_byte(8'h00, 1'b1, 1'b0);
    offer_byte(8'hFF, 1'b1, 1'b0);
    for (k = 0; k < 11; k++) offer_byte((k % 2) ? 8'h00 : 8'hFF, 1'b0, 1'b0);
    offer_byte(8'h3C, 1'b1, 1'b1);
    for (k = 0; k < 12; k++) offer_byte(8'h80 | 8'(k), k == 11, 1'b0);

    for (phase = 0; phase < PhaseCount; phase++) begin
      write_seed(seed_plan[phase]);
      case (phase / 2)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct <= 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct <= 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      if (phase == 4) begin
        // Hold the output back while short messages keep arriving, so the queue fills.
        hold_tog <= ~hold_tog;
        for (k = 0; k < 12; k++) send_message($urandom_range(1, 3), 1'b0);
      end
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        pick = $urandom_range(99);
        if (pick < 8)       n_bytes = 0;
        else if (pick < 70) n_bytes = $urandom_range(1, 24);
        else if (pick < 95) n_bytes = $urandom_range(25, 60);
        else                n_bytes = $urandom_range(61, 120);
        send_message(n_bytes, $urandom_range(9) == 0);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (hashes_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_total == 0 && hashes_pending == 0)
      $display("jenkins_lookup2_byte_hash_unit test passed");
    else
      $display("jenkins_lookup2_byte_hash_unit test failed");
    $finish;
  end

endmodule
